// ----- rtl/clock_set_menu_fsm_core_assert.svh -----
// Assertion macros shared by the clock set menu RTL.
// Used inside modules that have clk and rst_n in scope.
`ifndef CLOCK_SET_MENU_FSM_CORE_ASSERT_SVH
`define CLOCK_SET_MENU_FSM_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define CSM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define CSM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/csm_pkg.sv -----
// Types, codes and small helper functions for the clock set menu.
// No dependencies; imported by every module of the block.
package csm_pkg;

  // Commands
  localparam logic [1:0] CMD_MODE = 2'd0;
  localparam logic [1:0] CMD_FUNC = 2'd1;
  localparam logic [1:0] CMD_INIT = 2'd2;

  // Menu modes
  localparam logic [2:0] MODE_CLOCK     = 3'd1;
  localparam logic [2:0] MODE_ALARM     = 3'd2;
  localparam logic [2:0] MODE_CONF      = 3'd3;
  localparam logic [2:0] MODE_SET_HOUR  = 3'd4;
  localparam logic [2:0] MODE_SET_DAY   = 3'd5;
  localparam logic [2:0] MODE_SET_MONTH = 3'd6;

  // Views
  localparam logic [1:0] VIEW_PRI = 2'd1;
  localparam logic [1:0] VIEW_SEC = 2'd2;

  // Configuration targets
  localparam logic [1:0] TGT_NONE  = 2'd0;
  localparam logic [1:0] TGT_CLOCK = 2'd1;
  localparam logic [1:0] TGT_ALARM = 2'd2;

  // Display codes
  localparam logic [3:0] DISP_CLOCK      = 4'd0;
  localparam logic [3:0] DISP_MONTH      = 4'd1;
  localparam logic [3:0] DISP_ALARM      = 4'd2;
  localparam logic [3:0] DISP_CONFMODE   = 4'd3;
  localparam logic [3:0] DISP_CONFON     = 4'd4;
  localparam logic [3:0] DISP_MIN        = 4'd5;
  localparam logic [3:0] DISP_HOUR       = 4'd6;
  localparam logic [3:0] DISP_DATE       = 4'd7;
  localparam logic [3:0] DISP_SET_MONTH  = 4'd8;
  localparam logic [3:0] DISP_ALARM_MIN  = 4'd9;
  localparam logic [3:0] DISP_ALARM_HOUR = 4'd10;
  localparam logic [3:0] DISP_KEEP       = 4'd11;

  // Alarm actions
  localparam logic [1:0] ACT_NONE    = 2'd0;
  localparam logic [1:0] ACT_DISABLE = 2'd1;
  localparam logic [1:0] ACT_ENABLE  = 2'd2;

  // Wrap limits
  localparam logic [5:0] MINUTE_MAX = 6'd59;
  localparam logic [4:0] HOUR_MAX   = 5'd23;
  localparam logic [3:0] MONTH_MAX  = 4'd12;
  localparam logic [4:0] DAYS_LONG  = 5'd31;
  localparam logic [4:0] DAYS_SHORT = 5'd30;
  localparam logic [4:0] DAYS_FEB   = 5'd28;

  typedef struct packed {
    logic [2:0] mode;
    logic [1:0] view;
    logic       armed;
    logic [1:0] target;
    logic [3:0] month;
    logic [4:0] day;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [4:0] al_hour;
    logic [5:0] al_minute;
  } csm_state_t;

  typedef struct packed {
    logic [1:0] command;
    logic [3:0] now_month;
    logic [4:0] now_day;
    logic [4:0] now_hour;
    logic [5:0] now_minute;
    logic [4:0] alarm_hour;
    logic [5:0] alarm_minute;
  } csm_item_t;

  typedef struct packed {
    csm_state_t st;
    logic [3:0] disp;
    logic [1:0] act;
  } csm_result_t;

  function automatic logic [5:0] wrap_minute(input logic [5:0] v);
    return (v >= MINUTE_MAX) ? 6'd0 : v + 6'd1;
  endfunction

  function automatic logic [4:0] wrap_hour(input logic [4:0] v);
    return (v >= HOUR_MAX) ? 5'd0 : v + 5'd1;
  endfunction

  function automatic logic [3:0] wrap_month(input logic [3:0] v);
    return (v >= MONTH_MAX) ? 4'd1 : v + 4'd1;
  endfunction

  // Days in month, no leap years; zero for a month code outside 1..12
  function automatic logic [4:0] month_days(input logic [3:0] m);
    logic [4:0] d;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = DAYS_LONG;
      4'd4, 4'd6, 4'd9, 4'd11:                    d = DAYS_SHORT;
      4'd2:                                       d = DAYS_FEB;
      default:                                    d = 5'd0;
    endcase
    return d;
  endfunction

endpackage

// ----- rtl/csm_step.sv -----
// Next-state and display logic for one menu beat.
// Depends on csm_pkg.
module csm_step
  import csm_pkg::*;
(
  input  csm_state_t  st,
  input  csm_item_t   item,
  output csm_state_t  st_nxt,
  output logic [3:0]  disp,
  output logic [1:0]  act
);

  logic [4:0] day_lim;

  assign day_lim = month_days(st.month);

  // State update per command
  always_comb begin
    st_nxt = st;
    unique case (item.command)
      CMD_MODE: begin
        if (st.mode == MODE_CLOCK || st.mode == MODE_ALARM) begin
          st_nxt.mode = st.mode + 3'd1;
        end else if (st.mode == MODE_CONF) begin
          if (st.armed) begin
            st_nxt.mode = MODE_SET_HOUR;
          end else begin
            st_nxt.mode   = MODE_CLOCK;
            st_nxt.target = TGT_NONE;
            st_nxt.armed  = 1'b0;
          end
        end else if (st.target == TGT_NONE) begin
          if (st.mode == MODE_SET_HOUR) begin
            st_nxt.mode   = MODE_CLOCK;
            st_nxt.target = TGT_NONE;
            st_nxt.armed  = 1'b0;
          end
        end else if (st.target == TGT_CLOCK || st.target == TGT_ALARM) begin
          if (st.mode == MODE_SET_MONTH) begin
            st_nxt.mode   = MODE_CLOCK;
            st_nxt.target = TGT_NONE;
            st_nxt.armed  = 1'b0;
          end else begin
            st_nxt.mode = st.mode + 3'd1;
          end
        end
      end
      CMD_FUNC: begin
        unique case (st.mode)
          MODE_CLOCK, MODE_ALARM: begin
            st_nxt.view = (st.view == VIEW_PRI) ? VIEW_SEC : VIEW_PRI;
          end
          MODE_CONF: begin
            if (!st.armed) begin
              st_nxt.armed = 1'b1;
            end else if (st.target == TGT_NONE) begin
              st_nxt.target = TGT_CLOCK;
            end else if (st.target == TGT_CLOCK) begin
              st_nxt.minute = wrap_minute(st.minute);
            end else if (st.target == TGT_ALARM) begin
              st_nxt.al_minute = wrap_minute(st.al_minute);
            end
          end
          MODE_SET_HOUR: begin
            if (st.target == TGT_NONE) begin
              st_nxt.target = TGT_ALARM;
            end else if (st.target == TGT_CLOCK) begin
              st_nxt.hour = wrap_hour(st.hour);
            end
          end
          MODE_SET_DAY: begin
            if (st.target == TGT_CLOCK) begin
              if (day_lim != 5'd0) begin
                st_nxt.day = (st.day >= day_lim) ? 5'd1 : st.day + 5'd1;
              end
            end else if (st.target == TGT_ALARM) begin
              st_nxt.al_minute = wrap_minute(st.al_minute);
            end
          end
          MODE_SET_MONTH: begin
            if (st.target == TGT_CLOCK) begin
              st_nxt.month = wrap_month(st.month);
            end else if (st.target == TGT_ALARM) begin
              st_nxt.al_hour = wrap_hour(st.al_hour);
            end
          end
          default: begin
            // Mode code outside the menu: same as a reinit
            st_nxt.month     = item.now_month;
            st_nxt.day       = item.now_day;
            st_nxt.hour      = item.now_hour;
            st_nxt.minute    = item.now_minute;
            st_nxt.al_hour   = item.alarm_hour;
            st_nxt.al_minute = item.alarm_minute;
            st_nxt.mode      = MODE_CLOCK;
            st_nxt.view      = VIEW_PRI;
            st_nxt.target    = TGT_NONE;
            st_nxt.armed     = 1'b0;
          end
        endcase
      end
      CMD_INIT: begin
        st_nxt.month     = item.now_month;
        st_nxt.day       = item.now_day;
        st_nxt.hour      = item.now_hour;
        st_nxt.minute    = item.now_minute;
        st_nxt.al_hour   = item.alarm_hour;
        st_nxt.al_minute = item.alarm_minute;
        st_nxt.mode      = MODE_CLOCK;
        st_nxt.view      = VIEW_PRI;
        st_nxt.target    = TGT_NONE;
        st_nxt.armed     = 1'b0;
      end
      default: begin
        st_nxt = st;
      end
    endcase
  end

  // Display code and alarm action, only after a mode key
  always_comb begin
    disp = DISP_KEEP;
    act  = ACT_NONE;
    if (item.command == CMD_MODE) begin
      unique case (st_nxt.mode)
        MODE_CLOCK: begin
          if (st_nxt.view == VIEW_PRI) disp = DISP_CLOCK;
          else if (st_nxt.view == VIEW_SEC) disp = DISP_MONTH;
        end
        MODE_ALARM: begin
          disp = DISP_ALARM;
          if (st_nxt.view == VIEW_PRI) act = ACT_DISABLE;
          else if (st_nxt.view == VIEW_SEC) act = ACT_ENABLE;
        end
        MODE_CONF: begin
          if (!st_nxt.armed) disp = DISP_CONFMODE;
          else disp = (st_nxt.target == TGT_NONE) ? DISP_CONFON : DISP_MIN;
        end
        MODE_SET_HOUR: begin
          if (st_nxt.target == TGT_NONE) disp = DISP_ALARM;
          else if (st_nxt.target == TGT_CLOCK) disp = DISP_HOUR;
        end
        MODE_SET_DAY: begin
          if (st_nxt.target == TGT_CLOCK) disp = DISP_DATE;
          else if (st_nxt.target == TGT_ALARM) disp = DISP_ALARM_MIN;
        end
        MODE_SET_MONTH: begin
          if (st_nxt.target == TGT_CLOCK) disp = DISP_SET_MONTH;
          else if (st_nxt.target == TGT_ALARM) disp = DISP_ALARM_HOUR;
        end
        default: begin
          disp = DISP_KEEP;
        end
      endcase
    end
  end

endmodule

// ----- rtl/csm_out_reg.sv -----
// Result register of the clock set menu with valid/stall handshake.
// Depends on csm_pkg.
module csm_out_reg
  import csm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load,
  input  csm_result_t res,
  output logic        ready,
  input  logic        out_stall,
  output logic        out_valid,
  output csm_result_t out_res
);

  logic        valid_r;
  logic        valid_nxt;
  csm_result_t res_r;

  // Free when empty or when the held beat leaves this cycle
  assign ready     = !valid_r || !out_stall;
  assign valid_nxt = load ? 1'b1 : (ready ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

// ----- rtl/clock_set_menu_fsm_core.sv -----
// Clock set menu: two-key menu state machine with time and alarm editing.
// Input register, csm_step logic, csm_out_reg result register. Uses csm_pkg.
//
// Usage:
//   Input channel (in_*): one beat per key event: command 0 mode key,
//   1 function key, 2 reinit from the now_* and alarm_*_in fields.
//   Result channel (out_*): one beat per input beat, in order, carrying
//   the menu mode, view, armed flag, target, display code, alarm action,
//   the time being set and the alarm to store.
//   An accepted beat sits in the input register; csm_step computes its
//   result, which is loaded into the result register, and out_valid then
//   rises.
//   Throughput: one beat per cycle while out_stall is low; the only loop is
//   the menu state update through csm_step.
//   Stall: when out_stall holds the result register full, the input
//   register keeps its beat and in_stall rises; nothing is dropped.
//   Reset (rst_n low, synchronous): both registers empty, mode 1, view 1,
//   not armed, no target, date 1/1, time 00:00, alarm 00:00.

`include "clock_set_menu_fsm_core_assert.svh"

module clock_set_menu_fsm_core
  import csm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  // input channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_command,
  input  logic [3:0] in_now_month,
  input  logic [4:0] in_now_day,
  input  logic [4:0] in_now_hour,
  input  logic [5:0] in_now_minute,
  input  logic [4:0] in_alarm_hour_in,
  input  logic [5:0] in_alarm_minute_in,
  // result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_mode_out,
  output logic [1:0] out_view_out,
  output logic       out_config_armed,
  output logic [1:0] out_config_target,
  output logic [3:0] out_display_code,
  output logic [1:0] out_alarm_action,
  output logic [3:0] out_set_month,
  output logic [4:0] out_set_day,
  output logic [4:0] out_set_hour,
  output logic [5:0] out_set_minute,
  output logic [4:0] out_alarm_hour_out,
  output logic [5:0] out_alarm_minute_out
);

  logic        s1_valid_r;
  logic        s1_valid_nxt;
  csm_item_t   s1_item_r;
  csm_state_t  st_r;
  csm_state_t  st_nxt;
  csm_result_t res;
  csm_result_t out_res;
  logic        out_ready;
  logic        adv;
  logic        in_acc;
  logic [3:0]  disp;
  logic [1:0]  act;

  // Handshake between the two register stages
  assign adv          = s1_valid_r && out_ready;
  assign in_stall     = s1_valid_r && !out_ready;
  assign in_acc       = in_valid && !in_stall;
  assign s1_valid_nxt = in_acc ? 1'b1 : (adv ? 1'b0 : s1_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  // Input register payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r.command      <= in_command;
      s1_item_r.now_month    <= in_now_month;
      s1_item_r.now_day      <= in_now_day;
      s1_item_r.now_hour     <= in_now_hour;
      s1_item_r.now_minute   <= in_now_minute;
      s1_item_r.alarm_hour   <= in_alarm_hour_in;
      s1_item_r.alarm_minute <= in_alarm_minute_in;
    end
  end

  // Menu step
  csm_step u_step (
    .st     (st_r),
    .item   (s1_item_r),
    .st_nxt (st_nxt),
    .disp   (disp),
    .act    (act)
  );

  // Menu state, updated as each beat moves to the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.mode      <= MODE_CLOCK;
      st_r.view      <= VIEW_PRI;
      st_r.armed     <= 1'b0;
      st_r.target    <= TGT_NONE;
      st_r.month     <= 4'd1;
      st_r.day       <= 5'd1;
      st_r.hour      <= 5'd0;
      st_r.minute    <= 6'd0;
      st_r.al_hour   <= 5'd0;
      st_r.al_minute <= 6'd0;
    end else if (adv) begin
      st_r <= st_nxt;
    end
  end

  assign res.st   = st_nxt;
  assign res.disp = disp;
  assign res.act  = act;

  csm_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (adv),
    .res       (res),
    .ready     (out_ready),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  assign out_mode_out         = out_res.st.mode;
  assign out_view_out         = out_res.st.view;
  assign out_config_armed     = out_res.st.armed;
  assign out_config_target    = out_res.st.target;
  assign out_display_code     = out_res.disp;
  assign out_alarm_action     = out_res.act;
  assign out_set_month        = out_res.st.month;
  assign out_set_day          = out_res.st.day;
  assign out_set_hour         = out_res.st.hour;
  assign out_set_minute       = out_res.st.minute;
  assign out_alarm_hour_out   = out_res.st.al_hour;
  assign out_alarm_minute_out = out_res.st.al_minute;

  // Checks
  `CSM_ASSERT_NOW(a_mode_legal, 1'b1, st_r.mode != 3'd0 && st_r.mode != 3'd7, "bad mode")
  `CSM_ASSERT_NOW(a_target_needs_arm, !st_r.armed, st_r.target == TGT_NONE, "target unarmed")
  `CSM_ASSERT_NOW(a_target_legal, 1'b1, st_r.target != 2'd3, "illegal target code")
  `CSM_ASSERT_NEXT(a_adv_loads_out, adv, out_valid, "advanced beat missing at output")
  `CSM_ASSERT_NEXT(a_stall_holds_state, !adv, $stable(st_r), "menu state moved without a beat")

endmodule
